// ===== hw/rtl/ttm_pkg.sv =====
// Shared types and constants of the two-tier transaction matcher.
// Depends on nothing; the front, queue and back modules import it.
package ttm_pkg;

  // Classification of a candidate as decided by the front.
  localparam logic [1:0] KIND_SKIP     = 2'd0;
  localparam logic [1:0] KIND_FALLBACK = 2'd1;
  localparam logic [1:0] KIND_EXACT    = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [63:0] pair;
    logic        eye;
    logic [15:0] error;
    logic        finite;
  } ttm_item_t;

endpackage

// ===== hw/rtl/two_tier_transaction_matcher_top.sv =====
// Two-tier transaction matcher, top level. One candidate request is taken
// per cycle while the queue is not full; the front classifies it into a
// four-entry queue and the back updates the trackers as it drains it. The
// result is registered when the back takes the last request of a query
// and the output is free. Synchronous reset clears the query context, the
// trackers, the queue and the result flag, and sets max_error to 65535.
module two_tier_transaction_matcher_top
  import ttm_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first,
  input  logic        last,
  input  logic [31:0] query_mask,
  input  logic        incoming_signed,
  input  logic [1:0]  eye,
  input  logic [63:0] pair_id,
  input  logic [31:0] claim_mask,
  input  logic        sig_valid,
  input  logic [15:0] sig_error,
  input  logic        error_finite,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic        tier,
  output logic [7:0]  chosen_index,
  output logic [63:0] chosen_pair,
  output logic        chosen_eye,
  output logic [15:0] chosen_error,
  output logic        chosen_finite
);

  logic [15:0] max_error;
  logic        push;
  logic        queue_full;
  logic        pop;
  logic        head_valid;
  ttm_item_t   push_item;
  ttm_item_t   head_item;

  // Threshold register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_error <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      max_error <= cfg_data;
    end
  end

  ttm_front #(
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .first           (first),
    .last            (last),
    .query_mask      (query_mask),
    .incoming_signed (incoming_signed),
    .eye             (eye),
    .pair_id         (pair_id),
    .claim_mask      (claim_mask),
    .sig_valid       (sig_valid),
    .sig_error       (sig_error),
    .error_finite    (error_finite),
    .max_error       (max_error),
    .queue_full      (queue_full),
    .push            (push),
    .item            (push_item)
  );

  ttm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ttm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .matched       (matched),
    .tier          (tier),
    .chosen_index  (chosen_index),
    .chosen_pair   (chosen_pair),
    .chosen_eye    (chosen_eye),
    .chosen_error  (chosen_error),
    .chosen_finite (chosen_finite)
  );

endmodule

// ===== hw/rtl/ttm_front.sv =====
// Front of the matcher: accepts requests, holds the query context and
// classifies each candidate. Depends on ttm_pkg.
module ttm_front
  import ttm_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first,
  input  logic        last,
  input  logic [31:0] query_mask,
  input  logic        incoming_signed,
  input  logic [1:0]  eye,
  input  logic [63:0] pair_id,
  input  logic [31:0] claim_mask,
  input  logic        sig_valid,
  input  logic [15:0] sig_error,
  input  logic        error_finite,
  input  logic [15:0] max_error,
  input  logic        queue_full,
  output logic        push,
  output ttm_item_t   item
);

  localparam int POS_W = $clog2(MAX_CANDIDATES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CANDIDATES);

  logic [31:0]      held_mask;
  logic             held_signed;
  logic [POS_W-1:0] position;

  logic [31:0]        mask_now;
  logic               signed_now;
  logic [POS_W-1:0]   pos_now;
  logic               in_range;
  logic               eligible;
  logic [POS_W+7:0]   pos_ext;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // A first request restarts the query with its own mask and flag.
  assign mask_now   = first ? query_mask : held_mask;
  assign signed_now = first ? incoming_signed : held_signed;
  assign pos_now    = first ? '0 : position;
  assign in_range   = pos_now < POS_MAX;
  assign pos_ext    = {8'd0, pos_now};

  assign eligible = in_range && (mask_now != 32'd0) && !eye[1] &&
                    (pair_id != 64'd0) && (pair_id != {64{1'b1}}) &&
                    (claim_mask != 32'd0) &&
                    ((claim_mask & mask_now) == 32'd0);

  // Classify the candidate and pack the request for the back.
  always_comb begin
    item.first  = first;
    item.last   = last;
    item.index  = pos_ext[7:0];
    item.pair   = pair_id;
    item.eye    = eye[0];
    item.error  = error_finite ? sig_error : 16'd0;
    item.finite = error_finite;
    if (!eligible) begin
      item.kind = KIND_SKIP;
    end else if (!signed_now || !sig_valid) begin
      item.kind = KIND_FALLBACK;
    end else if (error_finite && (sig_error <= max_error)) begin
      item.kind = KIND_EXACT;
    end else begin
      item.kind = KIND_SKIP;
    end
  end

  // Query context and candidate position; a last request clears the position.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask   <= '0;
      held_signed <= 1'b0;
      position    <= '0;
    end else if (push) begin
      held_mask   <= mask_now;
      held_signed <= signed_now;
      if (last) begin
        position <= '0;
      end else if (in_range) begin
        position <= pos_now + POS_W'(1);
      end else begin
        position <= pos_now;
      end
    end
  end

endmodule

// ===== hw/rtl/ttm_queue.sv =====
// Short request queue that decouples the front from the back.
// Depends on ttm_pkg for the request type and depth.
module ttm_queue
  import ttm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ttm_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output ttm_item_t head_item
);

  ttm_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full       = count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ttm_back.sv =====
// Back of the matcher: updates the exact and fallback trackers and drives
// the registered result. Depends on ttm_pkg.
module ttm_back
  import ttm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  ttm_item_t   head_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic        tier,
  output logic [7:0]  chosen_index,
  output logic [63:0] chosen_pair,
  output logic        chosen_eye,
  output logic [15:0] chosen_error,
  output logic        chosen_finite
);

  logic        exact_found;
  logic [63:0] exact_pair;
  logic        exact_eye;
  logic [7:0]  exact_index;
  logic [15:0] exact_error;
  logic        fallback_found;
  logic [63:0] fallback_pair;
  logic        fallback_eye;
  logic [7:0]  fallback_index;
  logic [16:0] fallback_error;

  logic        ex_found_base;
  logic        fb_found_base;
  logic        fb_older;
  logic        ex_older;
  logic        take_fb;
  logic        take_ex;
  logic        ex_found_next;
  logic        fb_found_next;
  logic [63:0] ex_pair_next;
  logic        ex_eye_next;
  logic [7:0]  ex_index_next;
  logic [15:0] ex_error_next;
  logic [63:0] fb_pair_next;
  logic        fb_eye_next;
  logic [7:0]  fb_index_next;
  logic [16:0] fb_error_next;

  // The back moves on whenever the result register can take a new result.
  assign pop = head_valid && !(out_valid && out_stall);

  // A first request starts from empty trackers.
  assign ex_found_base = exact_found && !head_item.first;
  assign fb_found_base = fallback_found && !head_item.first;

  assign fb_older = (head_item.pair < fallback_pair) ||
                    ((head_item.pair == fallback_pair) &&
                     (head_item.eye < fallback_eye));
  assign ex_older = (head_item.pair < exact_pair) ||
                    ((head_item.pair == exact_pair) &&
                     (head_item.eye < exact_eye));

  assign take_fb = (head_item.kind == KIND_FALLBACK) && (!fb_found_base || fb_older);
  assign take_ex = (head_item.kind == KIND_EXACT) &&
                   (!ex_found_base || (head_item.error < exact_error) ||
                    ((head_item.error == exact_error) && ex_older));

  // Tracker values after this request.
  always_comb begin
    ex_found_next = ex_found_base || take_ex;
    ex_pair_next  = take_ex ? head_item.pair  : exact_pair;
    ex_eye_next   = take_ex ? head_item.eye   : exact_eye;
    ex_index_next = take_ex ? head_item.index : exact_index;
    ex_error_next = take_ex ? head_item.error : exact_error;
    fb_found_next = fb_found_base || take_fb;
    fb_pair_next  = take_fb ? head_item.pair  : fallback_pair;
    fb_eye_next   = take_fb ? head_item.eye   : fallback_eye;
    fb_index_next = take_fb ? head_item.index : fallback_index;
    fb_error_next = take_fb ? {head_item.finite, head_item.error} : fallback_error;
  end

  // Trackers; a last request clears them after its result is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_found    <= 1'b0;
      fallback_found <= 1'b0;
    end else if (pop) begin
      exact_found    <= ex_found_next && !head_item.last;
      fallback_found <= fb_found_next && !head_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      exact_pair     <= ex_pair_next;
      exact_eye      <= ex_eye_next;
      exact_index    <= ex_index_next;
      exact_error    <= ex_error_next;
      fallback_pair  <= fb_pair_next;
      fallback_eye   <= fb_eye_next;
      fallback_index <= fb_index_next;
      fallback_error <= fb_error_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= head_item.last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: exact match first, then fallback, otherwise all zero.
  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      if (ex_found_next) begin
        matched       <= 1'b1;
        tier          <= 1'b0;
        chosen_index  <= ex_index_next;
        chosen_pair   <= ex_pair_next;
        chosen_eye    <= ex_eye_next;
        chosen_error  <= ex_error_next;
        chosen_finite <= 1'b1;
      end else if (fb_found_next) begin
        matched       <= 1'b1;
        tier          <= 1'b1;
        chosen_index  <= fb_index_next;
        chosen_pair   <= fb_pair_next;
        chosen_eye    <= fb_eye_next;
        chosen_error  <= fb_error_next[15:0];
        chosen_finite <= fb_error_next[16];
      end else begin
        matched       <= 1'b0;
        tier          <= 1'b0;
        chosen_index  <= 8'd0;
        chosen_pair   <= 64'd0;
        chosen_eye    <= 1'b0;
        chosen_error  <= 16'd0;
        chosen_finite <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/match_checker.sv =====
`timescale 1ns / 1ps
// Checker for the two-tier transaction matcher: watches the configuration, request and result
// channels, predicts each query result and compares it field by field. Needs only the DUT ports.
module match_checker #(
  parameter int MAX_CANDIDATES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        first,
  input  logic        last,
  input  logic [31:0] query_mask,
  input  logic        incoming_signed,
  input  logic [1:0]  eye,
  input  logic [63:0] pair_id,
  input  logic [31:0] claim_mask,
  input  logic        sig_valid,
  input  logic [15:0] sig_error,
  input  logic        error_finite,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        matched,
  input  logic        tier,
  input  logic [7:0]  chosen_index,
  input  logic [63:0] chosen_pair,
  input  logic        chosen_eye,
  input  logic [15:0] chosen_error,
  input  logic        chosen_finite,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        matched;
    logic        tier;
    logic [7:0]  index;
    logic [63:0] pair;
    logic        eye;
    logic [15:0] error;
    logic        finite;
  } match_t;

  // Predicted query results, oldest first.
  match_t awaited_matches[$];

  // Mirror of the register and the query context.
  logic [15:0] max_error;
  logic [31:0] held_mask;
  logic        held_signed;
  int          slot_count;

  // Exact (signed) tracker.
  logic        ex_found;
  logic [63:0] ex_pair;
  logic        ex_eye;
  logic [7:0]  ex_index;
  logic [15:0] ex_error;

  // Fallback (oldest unsigned) tracker; bit 16 of the error is the finite flag.
  logic        fb_found;
  logic [63:0] fb_pair;
  logic        fb_eye;
  logic [7:0]  fb_index;
  logic [16:0] fb_error;

  function automatic bit older(logic [63:0] pa, logic ea, logic [63:0] pb, logic eb);
    return (pa < pb) || (pa == pb && ea < eb);
  endfunction

  task automatic clear_trackers();
    slot_count = 0;
    ex_found = 1'b0;
    ex_pair = '0;
    ex_eye = 1'b0;
    ex_index = '0;
    ex_error = '0;
    fb_found = 1'b0;
    fb_pair = '0;
    fb_eye = 1'b0;
    fb_index = '0;
    fb_error = '0;
  endtask

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (fail_count < 40) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    end
    fail_count++;
  endtask

  // Update the trackers with one accepted request and predict the result on the last one.
  task automatic take_candidate();
    logic [7:0] slot;
    logic       take;
    match_t     m;
    if (first) begin
      clear_trackers();
      held_mask = query_mask;
      held_signed = incoming_signed;
    end
    slot = slot_count[7:0];
    if (slot_count < MAX_CANDIDATES && held_mask != '0 && eye <= 2'd1 &&
        pair_id != '0 && pair_id != '1 && claim_mask != '0 &&
        (claim_mask & held_mask) == '0) begin
      if (!held_signed || !sig_valid) begin
        if (!fb_found || older(pair_id, eye[0], fb_pair, fb_eye)) begin
          fb_found = 1'b1;
          fb_pair = pair_id;
          fb_eye = eye[0];
          fb_index = slot;
          fb_error = error_finite ? {1'b1, sig_error} : 17'd0;
        end
      end else if (error_finite && sig_error <= max_error) begin
        take = !ex_found || sig_error < ex_error ||
               (sig_error == ex_error && older(pair_id, eye[0], ex_pair, ex_eye));
        if (take) begin
          ex_found = 1'b1;
          ex_pair = pair_id;
          ex_eye = eye[0];
          ex_index = slot;
          ex_error = sig_error;
        end
      end
    end
    if (slot_count < MAX_CANDIDATES) slot_count++;

    if (last) begin
      if (ex_found) begin
        m = '{1'b1, 1'b0, ex_index, ex_pair, ex_eye, ex_error, 1'b1};
      end else if (fb_found) begin
        m = '{1'b1, 1'b1, fb_index, fb_pair, fb_eye, fb_error[15:0], fb_error[16]};
      end else begin
        m = '0;
      end
      awaited_matches.push_back(m);
      clear_trackers();
    end
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic check_result();
    match_t want;
    if (awaited_matches.size() == 0) begin
      note_mismatch("unexpected result", {63'd0, matched}, 64'd0);
      return;
    end
    want = awaited_matches.pop_front();
    if (matched !== want.matched)
      note_mismatch("matched", 64'(matched), 64'(want.matched));
    if (tier !== want.tier) note_mismatch("tier", 64'(tier), 64'(want.tier));
    if (chosen_index !== want.index)
      note_mismatch("chosen_index", 64'(chosen_index), 64'(want.index));
    if (chosen_pair !== want.pair) note_mismatch("chosen_pair", chosen_pair, want.pair);
    if (chosen_eye !== want.eye)
      note_mismatch("chosen_eye", 64'(chosen_eye), 64'(want.eye));
    if (chosen_error !== want.error)
      note_mismatch("chosen_error", 64'(chosen_error), 64'(want.error));
    if (chosen_finite !== want.finite)
      note_mismatch("chosen_finite", 64'(chosen_finite), 64'(want.finite));
  endtask

  // All channels are sampled at the rising edge, results before requests.
  always @(posedge clk) begin
    if (rst) begin
      max_error = 16'hFFFF;
      held_mask = '0;
      held_signed = 1'b0;
      clear_trackers();
      awaited_matches.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_error = cfg_data;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_candidate();
    end
    pending = awaited_matches.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the two-tier transaction matcher: drives directed and random candidate
// requests, sets max_error between phases and gives the verdict. Depends on match_checker.
module tb_top;

  localparam int CAPACITY = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int LONG_QUERY = 270;
  localparam logic [15:0] ERR_MAX = 16'hFFFF;

  typedef struct {
    bit        first;
    bit        last;
    bit [31:0] qmask;
    bit        isig;
    bit [1:0]  eye;
    bit [63:0] pair;
    bit [31:0] claimed;
    bit        sigv;
    bit [15:0] err;
    bit        fin;
  } cand_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first = 1'b0;
  logic        last = 1'b0;
  logic [31:0] query_mask = '0;
  logic        incoming_signed = 1'b0;
  logic [1:0]  eye = '0;
  logic [63:0] pair_id = '0;
  logic [31:0] claim_mask = '0;
  logic        sig_valid = 1'b0;
  logic [15:0] sig_error = '0;
  logic        error_finite = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        matched;
  logic        tier;
  logic [7:0]  chosen_index;
  logic [63:0] chosen_pair;
  logic        chosen_eye;
  logic [15:0] chosen_error;
  logic        chosen_finite;
  int          fail_count;
  int          pending;

  // Stimulus controls.
  logic [15:0] cur_max = ERR_MAX;
  bit          calm = 1'b0;
  int          hold_requests = 0;
  int          cycle_count = 0;

  two_tier_transaction_matcher_top #(.MAX_CANDIDATES(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first(first), .last(last), .query_mask(query_mask),
    .incoming_signed(incoming_signed), .eye(eye), .pair_id(pair_id),
    .claim_mask(claim_mask), .sig_valid(sig_valid),
    .sig_error(sig_error), .error_finite(error_finite),
    .out_valid(out_valid), .out_stall(out_stall),
    .matched(matched), .tier(tier), .chosen_index(chosen_index),
    .chosen_pair(chosen_pair), .chosen_eye(chosen_eye),
    .chosen_error(chosen_error), .chosen_finite(chosen_finite)
  );

  match_checker #(.MAX_CANDIDATES(CAPACITY)) u_match_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first(first), .last(last), .query_mask(query_mask),
    .incoming_signed(incoming_signed), .eye(eye), .pair_id(pair_id),
    .claim_mask(claim_mask), .sig_valid(sig_valid),
    .sig_error(sig_error), .error_finite(error_finite),
    .out_valid(out_valid), .out_stall(out_stall),
    .matched(matched), .tier(tier), .chosen_index(chosen_index),
    .chosen_pair(chosen_pair), .chosen_eye(chosen_eye),
    .chosen_error(chosen_error), .chosen_finite(chosen_finite),
    .fail_count(fail_count), .pending(pending)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off per request from the stimulus.
  initial begin : result_sink
    int served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests > served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 22);
      end
    end
  end

  function automatic int idle_gap();
    int n = 0;
    if (calm) return 0;
    while (n < 8 && $urandom_range(99) < 22) n++;
    return n;
  endfunction

  // Offer one request and hold it until it is accepted.
  task automatic offer(input cand_t c);
    int gap;
    first <= c.first;
    last <= c.last;
    query_mask <= c.qmask;
    incoming_signed <= c.isig;
    eye <= c.eye;
    pair_id <= c.pair;
    claim_mask <= c.claimed;
    sig_valid <= c.sigv;
    sig_error <= c.err;
    error_finite <= c.fin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every predicted result, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_error(input logic [15:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max = value;
  endtask

  // A plain eligible signed candidate for the directed part.
  function automatic cand_t base_cand();
    cand_t c;
    c.first = 1'b0;
    c.last = 1'b0;
    c.qmask = 32'h0000_0001;
    c.isig = 1'b1;
    c.eye = 2'd0;
    c.pair = 64'd100;
    c.claimed = 32'h0000_0002;
    c.sigv = 1'b1;
    c.err = 16'h0080;
    c.fin = 1'b1;
    return c;
  endfunction

  function automatic logic [31:0] pick_mask();
    logic [31:0] m = '0;
    int roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 8) return '1;
    if (roll < 20) return $urandom;
    repeat ($urandom_range(1, 4)) m |= 32'h1 << $urandom_range(31);
    return m;
  endfunction

  // Random candidate, mostly eligible against the given mask.
  function automatic cand_t make_cand(input logic [31:0] qm);
    cand_t c;
    int roll;
    int near;
    c.first = 1'b0;
    c.last = 1'b0;
    c.qmask = $urandom;
    c.isig = 1'($urandom_range(1));
    c.eye = ($urandom_range(99) < 88) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3));
    roll = $urandom_range(99);
    if (roll < 40) c.pair = 64'($urandom_range(1, 6));
    else if (roll < 85) c.pair = {$urandom, $urandom};
    else if (roll < 90) c.pair = '0;
    else if (roll < 95) c.pair = '1;
    else c.pair = 64'hFFFF_FFFF_FFFF_FFFE;
    roll = $urandom_range(99);
    if (roll < 85) begin
      c.claimed = $urandom & ~qm;
      if (c.claimed == '0) c.claimed = ~qm;
    end else if (roll < 95) begin
      c.claimed = $urandom;
    end else begin
      c.claimed = '0;
    end
    c.sigv = ($urandom_range(99) < 70);
    roll = $urandom_range(99);
    if (roll < 30) begin
      c.err = 16'($urandom_range(4) * 64);
    end else if (roll < 70) begin
      c.err = 16'($urandom);
    end else if (roll < 80) begin
      c.err = ERR_MAX;
    end else begin
      near = int'(cur_max) + $urandom_range(4) - 2;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      c.err = 16'(near);
    end
    c.fin = ($urandom_range(99) < 85);
    return c;
  endfunction

  function automatic cand_t noise_cand();
    cand_t c;
    c.first = 1'($urandom_range(1));
    c.last = 1'($urandom_range(1));
    c.qmask = $urandom;
    c.isig = 1'($urandom_range(1));
    c.eye = 2'($urandom_range(3));
    c.pair = {$urandom, $urandom};
    c.claimed = $urandom;
    c.sigv = 1'($urandom_range(1));
    c.err = 16'($urandom);
    c.fin = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic directed_checks();
    cand_t c;
    // Zero query mask rejects the whole query.
    c = base_cand(); c.first = 1'b1; c.qmask = '0; c.claimed = 32'h1; offer(c);
    c = base_cand(); c.last = 1'b1; offer(c);
    // One-request query, exact match at the lowest error and oldest valid pair.
    c = base_cand(); c.first = 1'b1; c.last = 1'b1; c.pair = 64'd1; c.err = '0; offer(c);
    // Each kind of ineligible candidate, then fallbacks; the older eye wins, error not finite.
    c = base_cand(); c.first = 1'b1; c.eye = 2'd2; offer(c);
    c = base_cand(); c.eye = 2'd3; offer(c);
    c = base_cand(); c.pair = '0; offer(c);
    c = base_cand(); c.pair = '1; offer(c);
    c = base_cand(); c.claimed = '0; offer(c);
    c = base_cand(); c.claimed = 32'h3; offer(c);
    c = base_cand(); c.sigv = 1'b0; c.pair = 64'd50; c.eye = 2'd1; c.err = 16'd77; offer(c);
    c = base_cand(); c.last = 1'b1; c.sigv = 1'b0; c.pair = 64'd50; c.fin = 1'b0;
    c.err = 16'h1234; offer(c);
    // Exact ties: the older eye replaces; non-finite ignored; exact beats fallback.
    c = base_cand(); c.first = 1'b1; c.qmask = 32'h8000_0000; c.claimed = 32'h7FFF_FFFF;
    c.pair = 64'd10; c.eye = 2'd1; c.err = 16'd5; offer(c);
    c.first = 1'b0; c.eye = 2'd0; offer(c);
    c.pair = 64'd12; offer(c);
    c.pair = 64'd3; c.err = 16'd3; c.fin = 1'b0; offer(c);
    c.fin = 1'b1; c.err = ERR_MAX; offer(c);
    c.sigv = 1'b0; c.pair = 64'd2; c.last = 1'b1; offer(c);
    // Query without a first request keeps the held mask and signed flag.
    c = base_cand(); c.qmask = '0; c.isig = 1'b0; c.claimed = 32'h7FFF_FFFF;
    c.pair = 64'hFFFF_FFFF_FFFF_FFFE; c.eye = 2'd1; c.err = ERR_MAX; offer(c);
    c.last = 1'b1; c.claimed = 32'h8000_0000; c.pair = 64'd4; offer(c);
    // Unsigned incoming request turns signed candidates into fallbacks.
    c = base_cand(); c.first = 1'b1; c.isig = 1'b0; c.err = ERR_MAX; c.pair = 64'd900; offer(c);
    c.first = 1'b0; c.last = 1'b1; c.pair = 64'd800; c.claimed = 32'hFFFF_FFFE; offer(c);
  endtask

  // Mostly well-formed queries with random content, some noise and broken queries.
  task automatic run_queries(input int budget, input int max_len);
    cand_t       c;
    int          len;
    int          roll;
    logic [31:0] qm;
    bit          qs;
    bit          no_first;
    bit          no_last;
    int          sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        c = noise_cand();
        offer(c);
        sent++;
      end else begin
        len = $urandom_range(1, max_len);
        qm = pick_mask();
        qs = ($urandom_range(99) < 70);
        no_first = (roll < 14);
        no_last = (roll >= 96);
        for (int k = 0; k < len; k++) begin
          c = make_cand(qm);
          c.first = (k == 0) && !no_first;
          c.last = (k == len - 1) && !no_last;
          if (c.first) begin
            c.qmask = qm;
            c.isig = qs;
          end
          offer(c);
          sent++;
        end
      end
    end
  endtask

  // One query longer than the capacity; the requests past it would win if taken.
  task automatic capacity_query();
    cand_t       c;
    logic [31:0] qm = 32'h0000_0010;
    for (int k = 0; k < LONG_QUERY; k++) begin
      c = make_cand(qm);
      c.first = (k == 0);
      c.last = (k == LONG_QUERY - 1);
      c.qmask = qm;
      c.isig = 1'b1;
      if (k >= CAPACITY) begin
        c.eye = 2'd0;
        c.pair = 64'd1;
        c.claimed = 32'h1;
        c.sigv = (k % 2) != 0;
        c.err = '0;
        c.fin = 1'b1;
      end
      offer(c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_checks();
    settle();

    write_max_error(16'h0100);
    run_queries(30, 8);
    settle();

    // Results held off while short queries keep coming, so the block backs up.
    write_max_error(16'h0000);
    hold_requests <= hold_requests + 1;
    run_queries(40, 2);
    settle();

    // A stretch with no idling on either side.
    calm <= 1'b1;
    write_max_error(ERR_MAX);
    run_queries(40, 6);
    settle();
    calm <= 1'b0;

    write_max_error(16'($urandom));
    capacity_query();
    run_queries(30, 8);
    settle();

    write_max_error(16'($urandom_range(16'h0400)));
    run_queries(20, 10);
    settle();

    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
